>>> hw/rtl/rvbp_pkg.sv
// ----------------------------------------------------------------------------
// rvbp_pkg
// Shared types and constants for the run/value bit packer.
// ----------------------------------------------------------------------------
package rvbp_pkg;

	localparam int unsigned COEFF_W      = 12;
	localparam int unsigned RUN_W        = 6;
	localparam int unsigned VALUE_MAX_W  = 16;
	localparam int unsigned RUN_MAX_W    = 8;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned CNT_W        = 3;
	localparam int unsigned DEF_VALUE_W  = 12;
	localparam int unsigned DEF_RUN_W    = 6;
	localparam logic [RUN_W-1:0] END_CODE = 6'd63;

	// one packed job: up to four bytes, left-aligned
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  count;
		logic              blk_end;
	} job_t;

endpackage

>>> hw/rtl/rvbp_front.sv
// ----------------------------------------------------------------------------
// rvbp_front
// Accepts value/run pairs, merges them with the pending bits and forms one
// job per request that yields bytes. Holds the bit offset and partial byte.
// ----------------------------------------------------------------------------
module rvbp_front #(
	parameter int unsigned VALUE_WIDTH = rvbp_pkg::DEF_VALUE_W,
	parameter int unsigned RUN_WIDTH   = rvbp_pkg::DEF_RUN_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [rvbp_pkg::COEFF_W-1:0] coeff_value,
	input  logic [rvbp_pkg::RUN_W-1:0]          run_length,
	input  logic                                q_full,
	output logic                                push,
	output rvbp_pkg::job_t                      push_job
);
	import rvbp_pkg::*;

	localparam int unsigned PW = VALUE_WIDTH + RUN_WIDTH;

	logic [2:0]               off_q;
	logic [BYTE_W-1:0]        partial_q;
	logic [VALUE_MAX_W-1:0]   value_ext;
	logic [RUN_MAX_W-1:0]     run_ext;
	logic [PW-1:0]            payload;
	logic [WORD_W-1:0]        pl_word;
	logic [WORD_W-1:0]        word;
	logic [WORD_W-1:0]        shifted;
	logic [4:0]               total;
	logic [1:0]               nfull;
	logic [2:0]               rem;
	logic                     end_code;
	logic [CNT_W-1:0]         cnt;
	logic                     accept;

	always_comb begin
		value_ext = {{(VALUE_MAX_W-COEFF_W){coeff_value[COEFF_W-1]}}, coeff_value};
		run_ext   = {{(RUN_MAX_W-RUN_W){1'b0}}, run_length};
		payload   = {value_ext[VALUE_WIDTH-1:0], run_ext[RUN_WIDTH-1:0]};
		pl_word   = {payload, {(WORD_W-PW){1'b0}}};
		word      = {partial_q, {(WORD_W-BYTE_W){1'b0}}} | (pl_word >> off_q);
		total     = {2'b00, off_q} + 5'(PW);
		nfull     = total[4:3];
		rem       = total[2:0];
		end_code  = (run_length == END_CODE);
		cnt       = {1'b0, nfull} + {2'b00, (end_code && (rem != 3'd0))};
		shifted   = word << {nfull, 3'b000};
	end

	assign item_stall       = q_full;
	assign accept           = item_valid && !q_full;
	assign push             = accept && (cnt != '0);
	assign push_job.word    = word;
	assign push_job.count   = cnt;
	assign push_job.blk_end = end_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			partial_q <= '0;
		end else if (accept) begin
			if (end_code) begin
				off_q     <= '0;
				partial_q <= '0;
			end else begin
				off_q     <= rem;
				partial_q <= shifted[WORD_W-1 -: BYTE_W];
			end
		end
	end

endmodule

>>> hw/rtl/rvbp_queue.sv
// ----------------------------------------------------------------------------
// rvbp_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module rvbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rvbp_pkg::job_t push_job,
	output logic           full,
	output logic           head_valid,
	output rvbp_pkg::job_t head_job,
	input  logic           pop
);
	import rvbp_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/rvbp_back.sv
// ----------------------------------------------------------------------------
// rvbp_back
// Takes jobs from the queue and sends their bytes out one per cycle, unless
// byte_stall holds the output, through a registered output stage.
// ----------------------------------------------------------------------------
module rvbp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  rvbp_pkg::job_t              head_job,
	output logic                        pop,
	output logic                        byte_valid,
	input  logic                        byte_stall,
	output logic [rvbp_pkg::BYTE_W-1:0] out_byte_val,
	output logic                        last,
	output logic                        block_end
);
	import rvbp_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  left_q;
	logic              end_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              blk_end_q;
	logic              emit;
	logic              final_byte;

	assign final_byte = (left_q == CNT_W'(1));
	assign emit       = (left_q != '0) && (!valid_q || !byte_stall);
	assign pop        = head_valid && ((left_q == '0) || (final_byte && emit));

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= head_job.word;
			end_q  <= head_job.blk_end;
		end else if (emit) begin
			word_q <= word_q << BYTE_W;
		end
		if (emit) begin
			byte_q    <= word_q[WORD_W-1 -: BYTE_W];
			last_q    <= final_byte;
			blk_end_q <= final_byte && end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				left_q <= head_job.count;
			end else if (emit) begin
				left_q <= left_q - CNT_W'(1);
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!byte_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign byte_valid   = valid_q;
	assign out_byte_val = byte_q;
	assign last         = last_q;
	assign block_end    = blk_end_q;

endmodule

>>> hw/rtl/run_value_bit_packer.sv
// ----------------------------------------------------------------------------
// run_value_bit_packer
// Packs value and run-length pairs msb first into a byte stream.
// ----------------------------------------------------------------------------
// Each request appends VALUE_WIDTH value bits and RUN_WIDTH run bits to the
// stream; bytes leave on the output as they fill, one byte per cycle while
// byte_stall is low. A run length of 63 closes the block, flushing any
// partial byte zero-padded. The front takes one request per cycle while the
// two-entry job queue has room; the back drains one byte per cycle when
// not stalled, and a request yields zero to four bytes. Byte output is the
// rate limiting port.
// ----------------------------------------------------------------------------
module run_value_bit_packer #(
	parameter int unsigned VALUE_WIDTH = rvbp_pkg::DEF_VALUE_W,
	parameter int unsigned RUN_WIDTH   = rvbp_pkg::DEF_RUN_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [rvbp_pkg::COEFF_W-1:0] coeff_value,
	input  logic [rvbp_pkg::RUN_W-1:0]          run_length,
	output logic                                byte_valid,
	input  logic                                byte_stall,
	output logic [rvbp_pkg::BYTE_W-1:0]         out_byte_val,
	output logic                                last,
	output logic                                block_end
);
	import rvbp_pkg::*;

	logic q_full;
	logic push;
	job_t push_job;
	logic head_valid;
	job_t head_job;
	logic pop;

	rvbp_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.RUN_WIDTH  (RUN_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.coeff_value(coeff_value),
		.run_length (run_length),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	rvbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop)
	);

	rvbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte_val(out_byte_val),
		.last        (last),
		.block_end   (block_end)
	);

endmodule
